>>> sv/hsr_prp_supervision_parser_assert.svh
// ----------------------------------------------------------------------------
// HSR/PRP supervision parser assertion macros
// Property wrappers shared by the checker: same-cycle and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef HSR_PRP_SUPERVISION_PARSER_ASSERT_SVH
`define HSR_PRP_SUPERVISION_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HPSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hpsp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HPSP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hpsp assertion failed");

`endif

>>> sv/hpsp_pkg.sv
// ----------------------------------------------------------------------------
// hpsp_pkg
// Layout constants, status codes and shared types of the supervision parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hpsp_pkg;

    localparam logic [4:0] MIN_FRAME_BYTES = 5'd22;
    localparam logic [4:0] LAYOUT_BYTES    = 5'd22;
    localparam logic [4:0] COUNT_MAX       = 5'd31;

    localparam logic [7:0] TLV_LEN_MAC     = 8'd6;
    localparam logic [7:0] TLV_VDAN        = 8'd20;
    localparam logic [7:0] TLV_DANP        = 8'd21;
    localparam logic [7:0] TLV_DANH        = 8'd23;
    localparam logic [7:0] TLV_REDBOX      = 8'd30;
    localparam logic [7:0] TLV_END         = 8'd0;

    localparam logic [1:0] KIND_VDAN       = 2'd0;
    localparam logic [1:0] KIND_DANP       = 2'd1;
    localparam logic [1:0] KIND_DANH       = 2'd2;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT    = 3'd1;
    localparam logic [2:0] ST_BAD_TLV1_LEN = 3'd2;
    localparam logic [2:0] ST_BAD_TLV1_TYP = 3'd3;
    localparam logic [2:0] ST_BAD_TLV2     = 3'd4;
    localparam logic [2:0] ST_BAD_CLOSE    = 3'd5;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_step;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  path_id;
        logic [11:0] sup_version;
        logic [15:0] seq_number;
        logic [1:0]  node_kind;
        logic [47:0] node_mac;
        logic        redbox_present;
        logic [47:0] redbox_mac;
    } t_result;

endpackage

`default_nettype wire

>>> sv/hpsp_decode.sv
// ----------------------------------------------------------------------------
// hpsp_decode
// Per-frame capture state and byte-position decode of the supervision layout.
// ----------------------------------------------------------------------------
`default_nettype none

module hpsp_decode
    import hpsp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_step   i_step,
    output t_result      o_result
);

    logic [4:0]  r_count,    n_count;
    logic [15:0] r_header,   n_header;
    logic [15:0] r_seq,      n_seq;
    logic [7:0]  r_tlv_type, n_tlv_type;
    logic [1:0]  r_kind,     n_kind;
    logic [47:0] r_node_mac, n_node_mac;
    logic        r_rb_flag,  n_rb_flag;
    logic [47:0] r_rb_mac,   n_rb_mac;
    logic [2:0]  r_err,      n_err;
    logic        r_done,     n_done;

    always_comb begin
        n_count    = r_count;
        n_header   = r_header;
        n_seq      = r_seq;
        n_tlv_type = r_tlv_type;
        n_kind     = r_kind;
        n_node_mac = r_node_mac;
        n_rb_flag  = r_rb_flag;
        n_rb_mac   = r_rb_mac;
        n_err      = r_err;
        n_done     = r_done;
        o_result   = '0;

        if (i_step.valid) begin
            if (!r_done && r_count < LAYOUT_BYTES) begin
                case (r_count) inside
                    [5'd0:5'd1]: begin
                        n_header = {r_header[7:0], i_step.data};
                    end
                    [5'd2:5'd3]: begin
                        n_seq = {r_seq[7:0], i_step.data};
                    end
                    5'd4, 5'd12, 5'd20: begin
                        n_tlv_type = i_step.data;
                    end
                    5'd5: begin
                        // length is checked before type
                        if (i_step.data != TLV_LEN_MAC) begin
                            n_err  = ST_BAD_TLV1_LEN;
                            n_done = 1'b1;
                        end else if (r_tlv_type == TLV_VDAN) begin
                            n_kind = KIND_VDAN;
                        end else if (r_tlv_type == TLV_DANP) begin
                            n_kind = KIND_DANP;
                        end else if (r_tlv_type == TLV_DANH) begin
                            n_kind = KIND_DANH;
                        end else begin
                            n_err  = ST_BAD_TLV1_TYP;
                            n_done = 1'b1;
                        end
                    end
                    [5'd6:5'd11]: begin
                        n_node_mac = {r_node_mac[39:0], i_step.data};
                    end
                    5'd13: begin
                        // end TLV here closes the frame without a RedBox entry
                        if (r_tlv_type == TLV_END && i_step.data == TLV_END) begin
                            n_done = 1'b1;
                        end else if (i_step.data != TLV_LEN_MAC || r_tlv_type != TLV_REDBOX) begin
                            n_err  = ST_BAD_TLV2;
                            n_done = 1'b1;
                        end else begin
                            n_rb_flag = 1'b1;
                        end
                    end
                    [5'd14:5'd19]: begin
                        n_rb_mac = {r_rb_mac[39:0], i_step.data};
                    end
                    5'd21: begin
                        if (r_tlv_type == TLV_END && i_step.data == TLV_END) begin
                            n_done = 1'b1;
                        end else begin
                            n_err  = ST_BAD_CLOSE;
                            n_done = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (r_count != COUNT_MAX) begin
                n_count = r_count + 5'd1;
            end

            if (i_step.last) begin
                if (n_count < MIN_FRAME_BYTES) begin
                    o_result.status = ST_TOO_SHORT;
                end else begin
                    o_result.status         = n_err;
                    o_result.path_id        = n_header[15:12];
                    o_result.sup_version    = n_header[11:0];
                    o_result.seq_number     = n_seq;
                    o_result.node_kind      = n_kind;
                    o_result.node_mac       = n_node_mac;
                    o_result.redbox_present = n_rb_flag;
                    o_result.redbox_mac     = n_rb_mac;
                end
                // drop all frame state for the next frame
                n_count    = '0;
                n_header   = '0;
                n_seq      = '0;
                n_tlv_type = '0;
                n_kind     = '0;
                n_node_mac = '0;
                n_rb_flag  = 1'b0;
                n_rb_mac   = '0;
                n_err      = ST_OK;
                n_done     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_header   <= '0;
            r_seq      <= '0;
            r_tlv_type <= '0;
            r_kind     <= '0;
            r_node_mac <= '0;
            r_rb_flag  <= 1'b0;
            r_rb_mac   <= '0;
            r_err      <= ST_OK;
            r_done     <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_header   <= n_header;
            r_seq      <= n_seq;
            r_tlv_type <= n_tlv_type;
            r_kind     <= n_kind;
            r_node_mac <= n_node_mac;
            r_rb_flag  <= n_rb_flag;
            r_rb_mac   <= n_rb_mac;
            r_err      <= n_err;
            r_done     <= n_done;
        end
    end

endmodule

`default_nettype wire

>>> sv/hsr_prp_supervision_parser.sv
// ----------------------------------------------------------------------------
// hsr_prp_supervision_parser
// Byte-serial parser of HSR/PRP supervision payloads, one status word per frame.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+----------------------------------
//   input   | in        | i_valid / o_stall  | i_data_byte, i_frame_end
//   result  | out       | o_valid / i_stall  | o_status .. o_redbox_mac
//
// One byte per cycle while o_stall is low. A byte is held in the input register,
// then is decoded into the capture state; the frame's result is registered in the
// output register as its last byte leaves the input register.
// Reset is synchronous, active low, and clears all capture state and valids.
// o_stall rises only when a last byte waits in the input register while the
// output register still holds an untaken result.
// ----------------------------------------------------------------------------
`default_nettype none

module hsr_prp_supervision_parser
    import hpsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_frame_end,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [3:0]       o_path_id,
    output logic [11:0]      o_sup_version,
    output logic [15:0]      o_seq_number,
    output logic [1:0]       o_node_kind,
    output logic [47:0]      o_node_mac,
    output logic             o_redbox_present,
    output logic [47:0]      o_redbox_mac
);

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    t_step      w_step;
    logic       w_block;
    logic       w_fire;

    // hold a last byte until the output register can take its result
    assign w_block = r_in_valid && r_in_last && r_out_valid && i_stall;
    assign w_fire  = r_in_valid && !w_block;
    assign o_stall = w_block;

    assign w_step.valid = w_fire;
    assign w_step.data  = r_in_data;
    assign w_step.last  = r_in_last;

    hpsp_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!w_block) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_block) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_path_id        = r_out.path_id;
    assign o_sup_version    = r_out.sup_version;
    assign o_seq_number     = r_out.seq_number;
    assign o_node_kind      = r_out.node_kind;
    assign o_node_mac       = r_out.node_mac;
    assign o_redbox_present = r_out.redbox_present;
    assign o_redbox_mac     = r_out.redbox_mac;

endmodule

`default_nettype wire

>>> sv/hpsp_checker.sv
// ----------------------------------------------------------------------------
// hpsp_checker
// Port-level checks of the supervision parser result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsr_prp_supervision_parser_assert.svh"

module hpsp_checker
    import hpsp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_status,
    input wire logic [3:0]  o_path_id,
    input wire logic [1:0]  o_node_kind,
    input wire logic [47:0] o_node_mac,
    input wire logic        o_redbox_present,
    input wire logic [47:0] o_redbox_mac
);

    `HPSP_ASSERT_NXT(a_hold_stalled, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_status) && $stable(o_node_mac) && $stable(o_redbox_mac))

    `HPSP_ASSERT_IMP(a_short_zero, i_clk, i_rst_n, o_valid && o_status == ST_TOO_SHORT,
        o_path_id == 4'd0 && o_node_mac == 48'd0 && !o_redbox_present)

    `HPSP_ASSERT_IMP(a_tlv1_bad_no_node, i_clk, i_rst_n,
        o_valid && (o_status == ST_BAD_TLV1_LEN || o_status == ST_BAD_TLV1_TYP),
        o_node_kind == KIND_VDAN && o_node_mac == 48'd0 && !o_redbox_present)

    `HPSP_ASSERT_IMP(a_no_redbox_zero, i_clk, i_rst_n, o_valid && !o_redbox_present,
        o_redbox_mac == 48'd0)

endmodule

bind hsr_prp_supervision_parser hpsp_checker u_hpsp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_status         (o_status),
    .o_path_id        (o_path_id),
    .o_node_kind      (o_node_kind),
    .o_node_mac       (o_node_mac),
    .o_redbox_present (o_redbox_present),
    .o_redbox_mac     (o_redbox_mac)
);

`default_nettype wire

>>> dv/tb_hsr_prp_supervision_parser.sv
// ----------------------------------------------------------------------------
// tb_hsr_prp_supervision_parser
// Sends supervision frames byte by byte, both well-formed and damaged, with
// random gaps on the input side and random stalls on the result side. A
// scoreboard decodes every accepted byte on its own and checks each status
// word against the oldest one it expects.
// ----------------------------------------------------------------------------
module tb_hsr_prp_supervision_parser
    import hpsp_pkg::*;
;

    class supervision_scoreboard;
        logic [4:0]  cnt;
        logic [15:0] hdr;
        logic [15:0] seq;
        logic [7:0]  tlv_type;
        logic [1:0]  kind;
        logic [47:0] node_mac;
        logic        rb_flag;
        logic [47:0] rb_mac;
        logic [2:0]  err;
        logic        stopped;
        t_result     expected_results[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            cnt      = '0;
            hdr      = '0;
            seq      = '0;
            tlv_type = '0;
            kind     = '0;
            node_mac = '0;
            rb_flag  = 1'b0;
            rb_mac   = '0;
            err      = ST_OK;
            stopped  = 1'b0;
        endfunction

        function void stop_with(logic [2:0] code);
            err     = code;
            stopped = 1'b1;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            t_result r;
            int unsigned pos;
            r   = '0;
            pos = cnt;
            if (!stopped && cnt < LAYOUT_BYTES) begin
                if (pos <= 1) begin
                    hdr = {hdr[7:0], b};
                end else if (pos <= 3) begin
                    seq = {seq[7:0], b};
                end else if (pos == 4 || pos == 12 || pos == 20) begin
                    tlv_type = b;
                end else if (pos == 5) begin
                    // length is checked before type
                    if (b != TLV_LEN_MAC) begin
                        stop_with(ST_BAD_TLV1_LEN);
                    end else begin
                        case (tlv_type)
                            TLV_VDAN: kind = KIND_VDAN;
                            TLV_DANP: kind = KIND_DANP;
                            TLV_DANH: kind = KIND_DANH;
                            default:  stop_with(ST_BAD_TLV1_TYP);
                        endcase
                    end
                end else if (pos <= 11) begin
                    node_mac = {node_mac[39:0], b};
                end else if (pos == 13) begin
                    if (tlv_type == TLV_END && b == TLV_END) begin
                        stopped = 1'b1;
                    end else if (b != TLV_LEN_MAC || tlv_type != TLV_REDBOX) begin
                        stop_with(ST_BAD_TLV2);
                    end else begin
                        rb_flag = 1'b1;
                    end
                end else if (pos <= 19) begin
                    rb_mac = {rb_mac[39:0], b};
                end else if (pos == 21) begin
                    if (tlv_type == TLV_END && b == TLV_END) begin
                        stopped = 1'b1;
                    end else begin
                        stop_with(ST_BAD_CLOSE);
                    end
                end
            end
            if (cnt < COUNT_MAX) begin
                cnt = cnt + 5'd1;
            end
            if (last) begin
                if (cnt < MIN_FRAME_BYTES) begin
                    r.status = ST_TOO_SHORT;
                end else begin
                    r.status         = err;
                    r.path_id        = hdr[15:12];
                    r.sup_version    = hdr[11:0];
                    r.seq_number     = seq;
                    r.node_kind      = kind;
                    r.node_mac       = node_mac;
                    r.redbox_present = rb_flag;
                    r.redbox_mac     = rb_mac;
                end
                expected_results.push_back(r);
                clear();
            end
        endfunction

        function void check_result(t_result got);
            t_result exp;
            logic    bad;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected status word: status=%0d seq=%h", got.status,
                             got.seq_number);
                end
                return;
            end
            exp = expected_results.pop_front();
            bad = (got.status !== exp.status) || (got.path_id !== exp.path_id) ||
                  (got.sup_version !== exp.sup_version) ||
                  (got.seq_number !== exp.seq_number) ||
                  (got.node_kind !== exp.node_kind) || (got.node_mac !== exp.node_mac) ||
                  (got.redbox_present !== exp.redbox_present) ||
                  (got.redbox_mac !== exp.redbox_mac);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("status word mismatch at %0t", $time);
                    $display("  exp: st=%0d path=%h ver=%h seq=%h kind=%0d mac=%h rb=%b rbmac=%h",
                             exp.status, exp.path_id, exp.sup_version, exp.seq_number,
                             exp.node_kind, exp.node_mac, exp.redbox_present, exp.redbox_mac);
                    $display("  got: st=%0d path=%h ver=%h seq=%h kind=%0d mac=%h rb=%b rbmac=%h",
                             got.status, got.path_id, got.sup_version, got.seq_number,
                             got.node_kind, got.node_mac, got.redbox_present, got.redbox_mac);
                end
            end
        endfunction
    endclass

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [7:0]  i_data_byte  = 8'd0;
    logic        i_frame_end  = 1'b0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [3:0]  o_path_id;
    logic [11:0] o_sup_version;
    logic [15:0] o_seq_number;
    logic [1:0]  o_node_kind;
    logic [47:0] o_node_mac;
    logic        o_redbox_present;
    logic [47:0] o_redbox_mac;

    supervision_scoreboard sb;
    logic [7:0]  frame_bytes[$];
    int          bytes_sent;
    int          stall_left;
    bit          rx_quiet;
    logic [7:0]  near_codes[8];

    hsr_prp_supervision_parser u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_frame_end      (i_frame_end),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_path_id        (o_path_id),
        .o_sup_version    (o_sup_version),
        .o_seq_number     (o_seq_number),
        .o_node_kind      (o_node_kind),
        .o_node_mac       (o_node_mac),
        .o_redbox_present (o_redbox_present),
        .o_redbox_mac     (o_redbox_mac)
    );

    always #5 i_clk = ~i_clk;

    // result side: take words, then hold stall for a random stretch
    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            stall_left = 0;
            rx_quiet   = 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got.status         = o_status;
                got.path_id        = o_path_id;
                got.sup_version    = o_sup_version;
                got.seq_number     = o_seq_number;
                got.node_kind      = o_node_kind;
                got.node_mac       = o_node_mac;
                got.redbox_present = o_redbox_present;
                got.redbox_mac     = o_redbox_mac;
                sb.check_result(got);
                if ($urandom_range(0, 11) == 0) begin
                    rx_quiet = ~rx_quiet;
                end
                stall_left = rx_quiet ? 0 : $urandom_range(0, 17);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_stall <= (stall_left != 0);
        end
    end

    // Fill frame_bytes with a well-formed frame of random content, then
    // trim or pad it to len bytes.
    task automatic build_frame(input logic [7:0] t1, input bit with_rb, input int len);
        frame_bytes.delete();
        repeat (4) frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(t1);
        frame_bytes.push_back(TLV_LEN_MAC);
        repeat (6) frame_bytes.push_back(8'($urandom_range(0, 255)));
        if (with_rb) begin
            frame_bytes.push_back(TLV_REDBOX);
            frame_bytes.push_back(TLV_LEN_MAC);
            repeat (6) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        frame_bytes.push_back(TLV_END);
        frame_bytes.push_back(TLV_END);
        // pad past the closing end TLV; these bytes are only counted
        while (frame_bytes.size() < len) begin
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        while (frame_bytes.size() > len) begin
            void'(frame_bytes.pop_back());
        end
    endtask

    // overwrite header, sequence and both MACs with one value
    task automatic fill_fields(input logic [7:0] v);
        for (int k = 0; k < 4; k++) frame_bytes[k] = v;
        for (int k = 6; k < 12; k++) frame_bytes[k] = v;
        if (frame_bytes.size() > 19) begin
            for (int k = 14; k < 20; k++) frame_bytes[k] = v;
        end
    endtask

    task automatic send_frame(input bit quiet);
        int gap;
        for (int k = 0; k < frame_bytes.size(); k++) begin
            gap = quiet ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid     <= 1'b1;
            i_data_byte <= frame_bytes[k];
            i_frame_end <= (k == frame_bytes.size() - 1);
            do @(posedge i_clk); while (o_stall);
            sb.note_byte(frame_bytes[k], k == frame_bytes.size() - 1);
            bytes_sent++;
        end
    endtask

    initial begin
        int sel;
        int pick;
        logic [7:0] t1;
        sb         = new();
        bytes_sent = 0;
        near_codes = '{TLV_END, TLV_LEN_MAC, TLV_VDAN, TLV_DANP, TLV_DANH, TLV_REDBOX,
                       8'd7, 8'd22};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed frames
        build_frame(TLV_VDAN, 1'b0, 22);
        fill_fields(8'hFF);
        send_frame(1'b1);
        build_frame(TLV_DANP, 1'b1, 22);
        fill_fields(8'h00);
        send_frame(1'b1);
        build_frame(TLV_DANH, 1'b1, 40);    // counter saturation
        fill_fields(8'hA5);
        send_frame(1'b0);
        build_frame(8'd99, 1'b0, 22);       // bad length beats bad type
        frame_bytes[5] = 8'd7;
        send_frame(1'b1);
        build_frame(8'd22, 1'b1, 22);       // bad first type
        send_frame(1'b1);
        build_frame(TLV_VDAN, 1'b1, 22);    // bad second TLV length
        frame_bytes[13] = 8'd5;
        send_frame(1'b1);
        build_frame(TLV_DANP, 1'b1, 22);    // second TLV type 0, length 6
        frame_bytes[12] = TLV_END;
        send_frame(1'b1);
        build_frame(TLV_DANH, 1'b1, 25);    // bad closing TLV
        frame_bytes[20] = 8'd1;
        send_frame(1'b1);
        build_frame(TLV_VDAN, 1'b0, 1);     // too short
        send_frame(1'b1);
        build_frame(TLV_DANP, 1'b1, 21);
        send_frame(1'b1);

        // random frames
        while (bytes_sent < 1850) begin
            sel  = $urandom_range(0, 99);
            pick = $urandom_range(0, 2);
            t1   = (pick == 0) ? TLV_VDAN : (pick == 1) ? TLV_DANP : TLV_DANH;
            build_frame(t1, 1'($urandom_range(0, 1)),
                        ($urandom_range(0, 3) == 0) ? 22 + $urandom_range(0, 14) : 22);
            if (sel >= 70 && sel < 85) begin
                // damage one byte at a TLV position of the layout
                case ($urandom_range(0, 5))
                    0: pick = 4;
                    1: pick = 5;
                    2: pick = 12;
                    3: pick = 13;
                    4: pick = 20;
                    default: pick = 21;
                endcase
                frame_bytes[pick] = $urandom_range(0, 1) ? near_codes[$urandom_range(0, 7)]
                                                         : 8'($urandom_range(0, 255));
            end else if (sel >= 85 && sel < 93) begin
                build_frame(t1, 1'($urandom_range(0, 1)), $urandom_range(1, 21));
            end else if (sel >= 93) begin
                frame_bytes.delete();
                repeat ($urandom_range(1, 34)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            send_frame($urandom_range(0, 3) == 0);
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/hpsp_pkg.sv
sv/hpsp_decode.sv
sv/hsr_prp_supervision_parser.sv
sv/hpsp_checker.sv
dv/tb_hsr_prp_supervision_parser.sv
